[rtl/rope_pkg.sv]
// ----------------------------------------------------------------------------
// rope_pkg
// Shared constants, register codes and binary32 helper functions.
// ----------------------------------------------------------------------------
package rope_pkg;

	localparam int MAX_ROW = 64;
	localparam int IDX_W   = $clog2(MAX_ROW);
	localparam int CNT_W   = $clog2(MAX_ROW + 1);
	localparam int ROW_W   = 96;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

	localparam logic [1:0] MODE_HALF    = 2'd0;
	localparam logic [1:0] MODE_ADJ     = 2'd1;
	localparam logic [1:0] MODE_QUARTER = 2'd2;

	localparam logic CFG_MODE    = 1'b0;
	localparam logic CFG_ROW_LEN = 1'b1;

	// leading zero count over 50 bits
	function automatic logic [5:0] lzc50(input logic [49:0] x);
		logic [5:0] n;
		logic       found;
		n = 6'd0;
		found = 1'b0;
		for (int i = 49; i >= 0; i--) begin
			if (!found && x[i]) begin
				n = 6'(49 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// round a significand with its leading one at bit 47, value sig * 2^(e-174)
	function automatic logic [31:0] fp_round(input logic sign, input logic signed [10:0] e,
			input logic [47:0] sig, input logic st);
		logic [10:0] sh;
		logic [95:0] wide;
		logic [47:0] s2;
		logic        st2;
		logic [23:0] m;
		logic        g;
		logic        rs;
		logic        up;
		logic [9:0]  eb;
		logic [33:0] sum;
		sh = 11'd0;
		if (e < 11'sd1) begin
			sh = 11'(11'sd1 - e);
		end
		if (sh > 11'd49) begin
			sh = 11'd49;
		end
		wide = {sig, 48'b0} >> sh[5:0];
		s2 = wide[95:48];
		st2 = st | (|wide[47:0]);
		m = s2[47:24];
		g = s2[23];
		rs = st2 | (|s2[22:0]);
		up = g & (rs | m[0]);
		eb = (e >= 11'sd1) ? 10'(e - 11'sd1) : 10'd0;
		sum = 34'({eb, 23'b0}) + 34'(m) + 34'(up);
		if (sum >= (34'd255 << 23)) begin
			return {sign, 8'hFF, 23'b0};
		end
		return {sign, sum[30:0]};
	endfunction

endpackage

[rtl/rotary_position_embedding.sv]
// ----------------------------------------------------------------------------
// rotary_position_embedding
// Buffers one row of value, sine and cosine, then emits the rotated row.
// ----------------------------------------------------------------------------
// The block takes a row of L elements (L = row_len with bit 0 cleared,
// limited to 2..64) at one element per cycle, one transfer each. After the
// last element it stops taking input and emits L results in element order.
// A rotated result passes through a row buffer read, a launch into the
// shared multiply-add unit, the work of that unit (two rounded products
// and a rounded sum), a wait for its done strobe and the output state;
// passthrough elements of quarter mode only pass read, launch and output.
// Each result waits in the output state until m_tready takes it, and the
// next element is read only then. Configuration writes drop a partial row.
module rotary_position_embedding (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // value, sine, cosine
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // rotated
	output logic        m_tlast,   // row_end
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);
	import rope_pkg::*;

	typedef enum logic [4:0] {
		ST_FILL   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_LAUNCH = 5'b00100,
		ST_WAIT   = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	localparam logic [CNT_W-1:0] TOP_LEN = CNT_W'(MAX_ROW & ~1);

	state_t           state_q;
	logic [1:0]       mode_q;
	logic [6:0]       row_len_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] d_q;
	logic [CNT_W-1:0] len;
	logic [CNT_W-1:0] half, quarter;
	logic [6:0]       rl;
	logic [CNT_W-1:0] partner;
	logic             neg, pass;
	logic             neg_s1, pass_s1;
	logic [31:0]      res_q;
	logic             last_q;
	logic             in_xfer;
	logic [ROW_W-1:0] rdata_a;
	logic [31:0]      rdata_b;
	logic             fpu_start;
	logic             fpu_done;
	logic [31:0]      fpu_result;

	always_comb begin
		rl = row_len_q & 7'h7E;
		if (rl < 7'd2) begin
			len = CNT_W'(2);
		end else if (8'(rl) > 8'(TOP_LEN)) begin
			len = TOP_LEN;
		end else begin
			len = CNT_W'(rl);
		end
		half = len >> 1;
		quarter = len >> 2;
	end

	// partner selection for the element being read
	always_comb begin
		neg = 1'b0;
		pass = 1'b0;
		case (mode_q)
			MODE_HALF: begin
				if (d_q < half) begin
					partner = d_q + half;
					neg = 1'b1;
				end else begin
					partner = d_q - half;
				end
			end
			MODE_ADJ: begin
				if (!d_q[0]) begin
					partner = d_q + CNT_W'(1);
					neg = 1'b1;
				end else begin
					partner = d_q - CNT_W'(1);
				end
			end
			default: begin
				if (d_q < quarter) begin
					partner = d_q + quarter;
					neg = 1'b1;
				end else if (d_q < half) begin
					partner = d_q - quarter;
				end else begin
					partner = d_q;
					pass = 1'b1;
				end
			end
		endcase
	end

	assign in_xfer = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_FILL);
	assign fpu_start = (state_q == ST_LAUNCH) && !pass_s1;

	rope_store u_store (
		.clk     (clk),
		.we      (in_xfer),
		.waddr   (fill_q[IDX_W-1:0]),
		.wdata   (s_tdata),
		.raddr_a (d_q[IDX_W-1:0]),
		.raddr_b (partner[IDX_W-1:0]),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	rope_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fpu_start),
		.x      (rdata_a[31:0]),
		.c      (rdata_a[95:64]),
		.p      (rdata_b ^ {neg_s1, 31'd0}),
		.s      (rdata_a[63:32]),
		.done   (fpu_done),
		.result (fpu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			mode_q <= MODE_ADJ;
			row_len_q <= 7'd64;
			fill_q <= '0;
			d_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MODE:    mode_q <= cfg_data[1:0];
					CFG_ROW_LEN: row_len_q <= cfg_data;
					default: ;
				endcase
				fill_q <= '0;
			end
			unique case (state_q)
				ST_FILL: begin
					if (in_xfer && !cfg_we) begin
						if (fill_q + CNT_W'(1) >= len) begin
							fill_q <= '0;
							d_q <= '0;
							state_q <= ST_READ;
						end else begin
							fill_q <= fill_q + CNT_W'(1);
						end
					end
				end
				ST_READ:   state_q <= ST_LAUNCH;
				ST_LAUNCH: state_q <= pass_s1 ? ST_OUT : ST_WAIT;
				ST_WAIT: begin
					if (fpu_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						if (last_q) begin
							state_q <= ST_FILL;
						end else begin
							d_q <= d_q + CNT_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			neg_s1 <= neg;
			pass_s1 <= pass;
			last_q <= (d_q + CNT_W'(1) == len);
		end
		if ((state_q == ST_LAUNCH) && pass_s1) begin
			res_q <= rdata_a[31:0];
		end else if ((state_q == ST_WAIT) && fpu_done) begin
			res_q <= fpu_result;
		end
	end

	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata = res_q;
	assign m_tlast = last_q;

endmodule

[rtl/rope_store.sv]
// ----------------------------------------------------------------------------
// rope_store
// Row buffer: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rope_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [rope_pkg::IDX_W-1:0] waddr,
	input  logic [rope_pkg::ROW_W-1:0] wdata,
	input  logic [rope_pkg::IDX_W-1:0] raddr_a,
	input  logic [rope_pkg::IDX_W-1:0] raddr_b,
	output logic [rope_pkg::ROW_W-1:0] rdata_a,   // value, sine, cosine
	output logic [31:0]                rdata_b    // partner value
);
	import rope_pkg::*;

	logic [ROW_W-1:0] mem [MAX_ROW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b][31:0];
	end

endmodule

[rtl/rope_fpu.sv]
// ----------------------------------------------------------------------------
// rope_fpu
// Multi-cycle binary32 unit computing x*c + p*s with separate roundings.
// ----------------------------------------------------------------------------
module rope_fpu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] x,
	input  logic [31:0] c,
	input  logic [31:0] p,
	input  logic [31:0] s,
	output logic        done,
	output logic [31:0] result
);
	import rope_pkg::*;

	typedef enum logic [6:0] {
		F_IDLE  = 7'b0000001,
		F_PROD  = 7'b0000010,
		F_NORM  = 7'b0000100,
		F_RND   = 7'b0001000,
		F_ALIGN = 7'b0010000,
		F_ANORM = 7'b0100000,
		F_ARND  = 7'b1000000
	} fpu_state_t;

	fpu_state_t state_q;
	logic       second_q;
	logic       done_q;
	logic [31:0] x_q, c_q, p_q, s_q, a_q, b_q, result_q;

	// multiply path
	logic [31:0] op0, op1;
	logic [7:0]  e0, e1;
	logic [23:0] m0, m1;
	logic        nan0, nan1, inf0, inf1, z0, z1;

	logic [47:0] prod_s1;
	logic [8:0]  esum_s1;
	logic        sign_s1, spec_s1;
	logic [31:0] specv_s1;
	logic [47:0] sig_s2;
	logic signed [10:0] e_s2;
	logic        sign_s2, spec_s2;
	logic [31:0] specv_s2;
	logic [5:0]  mlz;

	// add path
	logic [7:0]  ea, eb2;
	logic        anan, bnan, ainf, binf;
	logic        swap;
	logic [31:0] big, sml;
	logic [7:0]  ebig, esml, dexp;
	logic [49:0] tbig, tsml;
	logic [99:0] awide;
	logic [49:0] ssh;
	logic [49:0] rsum;
	logic        aspec;
	logic [31:0] aspecv;

	logic [49:0] r_s1;
	logic [7:0]  ae_s1;
	logic        asign_s1, aspec_s1;
	logic [31:0] aspecv_s1;
	logic [47:0] asig_s2;
	logic        ast_s2, azero_s2, asign_s2, aspec_s2;
	logic signed [10:0] ae_s2;
	logic [31:0] aspecv_s2;
	logic [5:0]  alz;
	logic [49:0] rn;

	assign op0 = second_q ? p_q : x_q;
	assign op1 = second_q ? s_q : c_q;

	always_comb begin
		e0 = op0[30:23];
		e1 = op1[30:23];
		m0 = {e0 != 8'd0, op0[22:0]};
		m1 = {e1 != 8'd0, op1[22:0]};
		nan0 = (e0 == 8'hFF) && (op0[22:0] != 23'd0);
		nan1 = (e1 == 8'hFF) && (op1[22:0] != 23'd0);
		inf0 = (e0 == 8'hFF) && (op0[22:0] == 23'd0);
		inf1 = (e1 == 8'hFF) && (op1[22:0] == 23'd0);
		z0 = (op0[30:0] == 31'd0);
		z1 = (op1[30:0] == 31'd0);
	end

	assign mlz = lzc50({prod_s1, 2'b00});

	// adder operand classification and alignment
	always_comb begin
		ea = a_q[30:23];
		eb2 = b_q[30:23];
		anan = (ea == 8'hFF) && (a_q[22:0] != 23'd0);
		bnan = (eb2 == 8'hFF) && (b_q[22:0] != 23'd0);
		ainf = (ea == 8'hFF) && (a_q[22:0] == 23'd0);
		binf = (eb2 == 8'hFF) && (b_q[22:0] == 23'd0);
		aspec = 1'b1;
		aspecv = CANON_NAN;
		if (anan || bnan || (ainf && binf && (a_q[31] != b_q[31]))) begin
			aspecv = CANON_NAN;
		end else if (ainf) begin
			aspecv = a_q;
		end else if (binf) begin
			aspecv = b_q;
		end else if ((a_q[30:0] == 31'd0) && (b_q[30:0] == 31'd0)) begin
			aspecv = {a_q[31] & b_q[31], 31'd0};
		end else begin
			aspec = 1'b0;
		end
		swap = b_q[30:0] > a_q[30:0];
		big = swap ? b_q : a_q;
		sml = swap ? a_q : b_q;
		ebig = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		esml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		dexp = ebig - esml;
		tbig = {1'b0, big[30:23] != 8'd0, big[22:0], 25'b0};
		tsml = {1'b0, sml[30:23] != 8'd0, sml[22:0], 25'b0};
		awide = {tsml, 50'b0} >> dexp[5:0];
		if (dexp > 8'd49) begin
			ssh = {49'd0, tsml != 50'd0};
		end else begin
			ssh = awide[99:50];
			ssh[0] = ssh[0] | (|awide[49:0]);
		end
		rsum = (big[31] ^ sml[31]) ? (tbig - ssh) : (tbig + ssh);
	end

	assign alz = lzc50(r_s1);
	assign rn = r_s1 << alz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			second_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						second_q <= 1'b0;
						state_q <= F_PROD;
					end
				end
				F_PROD:  state_q <= F_NORM;
				F_NORM:  state_q <= F_RND;
				F_RND: begin
					if (!second_q) begin
						second_q <= 1'b1;
						state_q <= F_PROD;
					end else begin
						state_q <= F_ALIGN;
					end
				end
				F_ALIGN: state_q <= F_ANORM;
				F_ANORM: state_q <= F_ARND;
				F_ARND: begin
					done_q <= 1'b1;
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == F_IDLE) && start) begin
			x_q <= x;
			c_q <= c;
			p_q <= p;
			s_q <= s;
		end
		// product stage
		prod_s1 <= m0 * m1;
		esum_s1 <= 9'((e0 == 8'd0) ? 8'd1 : e0) + 9'((e1 == 8'd0) ? 8'd1 : e1);
		sign_s1 <= op0[31] ^ op1[31];
		spec_s1 <= nan0 || nan1 || inf0 || inf1 || z0 || z1;
		if (nan0 || nan1 || (inf0 && z1) || (z0 && inf1)) begin
			specv_s1 <= CANON_NAN;
		end else if (inf0 || inf1) begin
			specv_s1 <= {op0[31] ^ op1[31], 8'hFF, 23'd0};
		end else begin
			specv_s1 <= {op0[31] ^ op1[31], 31'd0};
		end
		// normalize stage
		sig_s2 <= prod_s1 << mlz;
		e_s2 <= $signed({2'b00, esum_s1}) - 11'sd126 - $signed({5'b0, mlz});
		sign_s2 <= sign_s1;
		spec_s2 <= spec_s1;
		specv_s2 <= specv_s1;
		if (state_q == F_RND) begin
			if (!second_q) begin
				a_q <= spec_s2 ? specv_s2 : fp_round(sign_s2, e_s2, sig_s2, 1'b0);
			end else begin
				b_q <= spec_s2 ? specv_s2 : fp_round(sign_s2, e_s2, sig_s2, 1'b0);
			end
		end
		// add stages
		r_s1 <= rsum;
		ae_s1 <= ebig;
		asign_s1 <= big[31];
		aspec_s1 <= aspec;
		aspecv_s1 <= aspecv;
		asig_s2 <= rn[49:2];
		ast_s2 <= |rn[1:0];
		ae_s2 <= $signed({3'b000, ae_s1}) + 11'sd1 - $signed({5'b0, alz});
		azero_s2 <= (r_s1 == 50'd0);
		asign_s2 <= asign_s1;
		aspec_s2 <= aspec_s1;
		aspecv_s2 <= aspecv_s1;
		if (state_q == F_ARND) begin
			if (aspec_s2) begin
				result_q <= aspecv_s2;
			end else if (azero_s2) begin
				result_q <= 32'd0;
			end else begin
				result_q <= fp_round(asign_s2, ae_s2, asig_s2, ast_s2);
			end
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

[rtl/rope_checker.sv]
// ----------------------------------------------------------------------------
// rope_checker
// Port-level checks on the stream handshakes of rotary_position_embedding.
// ----------------------------------------------------------------------------
module rope_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	// loading and emitting never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result is offered");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// a result needs a buffer read first
	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid)
		else $error("result right after input transfer");

	a_row_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
		else $error("block not back to loading after row end");

endmodule

bind rotary_position_embedding rope_checker u_rope_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
